// ----- hw/rtl/sar_pkg.sv -----
`timescale 1ns / 1ps

package sar_pkg;

  // Field widths of the stream payload.
  localparam int CMD_W   = 2;
  localparam int SLOT_FW = 10;
  localparam int GEN_W   = 16;
  localparam int CNT_FW  = 11;
  localparam int STAT_W  = 2;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;

  localparam int POOL_SLOTS_DEF = 1024;
  localparam int GEN_LIMIT_DEF  = 65535;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MODE  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } sar_state_t;

endpackage

// ----- hw/rtl/slot_allocator_fifo_recycle.sv -----
`timescale 1ns / 1ps

// Slot allocator with per-slot generation counters and an optional recycle queue.
// Each input beat carries a command in in_tuser: allocate, free, or set the
// recycling mode. Every command produces exactly one result beat with the
// granted slot, its generation, a status code and the live and queued totals.
// Allocate, free, mode changes that disarm or keep the mode, and unknown
// commands use the accept cycle, which reads the slot memory and the link
// memory, and the next cycle, which writes back and loads the result register.
// Arming the recycle queue walks every slot below the high-water mark through
// the single read port of the slot memory, one slot per cycle, before the
// result of that beat is loaded. A new beat is taken once the block is idle
// and the result register is empty or being drained in the same cycle. The
// alive bits and generations share one memory; slots at or above the
// high-water mark have never been touched and are written fresh when handed
// out, so no clearing pass follows reset. The recycle queue is a linked list
// held in a second memory, with head, tail and count in registers.
module slot_allocator_fifo_recycle
  import sar_pkg::*;
#(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF,
  parameter int GEN_LIMIT  = GEN_LIMIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [9:0] target_slot, [10] recycle_on, [15:11] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] cmd
  input  logic [CMD_W-1:0]      in_tuser,

  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [9:0] granted_slot, [25:10] granted_generation, [36:26] alive_total,
  // [47:37] queued_total
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [STAT_W-1:0]     out_tuser
);

  localparam int SLOT_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int CNT_W  = $clog2(POOL_SLOTS + 1);
  localparam int CMP_W  = (CNT_W > CNT_FW) ? CNT_W : CNT_FW;
  localparam int ENT_W  = GEN_W + 1;

  // Input fields.
  logic [SLOT_FW-1:0] in_target;
  logic               in_recycle_on;
  logic               in_fire;
  logic               out_fire;

  assign in_target     = in_tdata[SLOT_FW-1:0];
  assign in_recycle_on = in_tdata[SLOT_FW];
  assign in_fire       = in_tvalid && in_tready;
  assign out_fire      = out_tvalid && out_tready;

  // Control and bookkeeping registers.
  sar_state_t        state_r, state_nxt;
  logic              armed_r, armed_nxt;
  logic [CNT_W-1:0]  mark_r, mark_nxt;
  logic [CNT_W-1:0]  live_r, live_nxt;
  logic [CNT_W-1:0]  qcnt_r, qcnt_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic              scan_vld_r, scan_vld_nxt;
  logic [SLOT_W-1:0] scan_slot_r, scan_slot_nxt;

  // Command captured at accept.
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [SLOT_W-1:0] tgt_r, tgt_nxt;
  logic              tgt_ok_r, tgt_ok_nxt;

  // Result register.
  logic               out_valid_r, out_valid_nxt;
  logic [SLOT_FW-1:0] out_slot_r, out_slot_nxt;
  logic [STAT_W-1:0]  out_stat_r, out_stat_nxt;
  logic [GEN_W-1:0]   out_gen_r, out_gen_nxt;
  logic [CNT_FW-1:0]  out_live_r, out_live_nxt;
  logic [CNT_FW-1:0]  out_free_r, out_free_nxt;

  // Memory ports.
  logic              slot_wr_en, slot_rd_en;
  logic [SLOT_W-1:0] slot_wr_addr, slot_rd_addr;
  logic [ENT_W-1:0]  slot_wr_data, slot_rd_data;
  logic              link_wr_en, link_rd_en;
  logic [SLOT_W-1:0] link_wr_addr, link_rd_addr;
  logic [SLOT_W-1:0] link_wr_data, link_rd_data;

  logic              rd_alive;
  logic [GEN_W-1:0]  rd_gen;
  logic [GEN_W-1:0]  gen_inc;
  logic              load;

  assign rd_alive = slot_rd_data[GEN_W];
  assign rd_gen   = slot_rd_data[GEN_W-1:0];
  assign gen_inc  = rd_gen + GEN_W'(1);

  // Alive bit and generation of every slot.
  sar_ram #(
    .DEPTH (POOL_SLOTS),
    .WIDTH (ENT_W)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_wr_en),
    .wr_addr (slot_wr_addr),
    .wr_data (slot_wr_data),
    .rd_en   (slot_rd_en),
    .rd_addr (slot_rd_addr),
    .rd_data (slot_rd_data)
  );

  // Forward links of the recycle queue.
  sar_ram #(
    .DEPTH (POOL_SLOTS),
    .WIDTH (SLOT_W)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_wr_en),
    .wr_addr (link_wr_addr),
    .wr_data (link_wr_data),
    .rd_en   (link_rd_en),
    .rd_addr (link_rd_addr),
    .rd_data (link_rd_data)
  );

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    armed_nxt     = armed_r;
    mark_nxt      = mark_r;
    live_nxt      = live_r;
    qcnt_nxt      = qcnt_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    scan_idx_nxt  = scan_idx_r;
    scan_vld_nxt  = scan_vld_r;
    scan_slot_nxt = scan_slot_r;
    cmd_nxt       = cmd_r;
    tgt_nxt       = tgt_r;
    tgt_ok_nxt    = tgt_ok_r;

    slot_wr_en    = 1'b0;
    slot_wr_addr  = tgt_r;
    slot_wr_data  = '0;
    slot_rd_en    = 1'b0;
    slot_rd_addr  = head_r;
    link_wr_en    = 1'b0;
    link_wr_addr  = tail_r;
    link_wr_data  = tgt_r;
    link_rd_en    = 1'b0;
    link_rd_addr  = head_r;

    load          = 1'b0;
    out_slot_nxt  = out_slot_r;
    out_stat_nxt  = out_stat_r;
    out_gen_nxt   = out_gen_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt    = in_tuser;
          tgt_nxt    = SLOT_W'(in_target);
          tgt_ok_nxt = CMP_W'(in_target) < CMP_W'(mark_r);
          slot_rd_en = 1'b1;
          link_rd_en = 1'b1;
          if (in_tuser == CMD_FREE) begin
            slot_rd_addr = SLOT_W'(in_target);
          end
          state_nxt = S_EXEC;
          if (in_tuser == CMD_MODE && in_recycle_on != armed_r) begin
            // A mode change always empties the queue; arming then rebuilds it.
            armed_nxt = in_recycle_on;
            qcnt_nxt  = '0;
            head_nxt  = '0;
            tail_nxt  = '0;
            if (in_recycle_on) begin
              scan_idx_nxt = '0;
              scan_vld_nxt = 1'b0;
              state_nxt    = S_SCAN;
            end
          end
        end
      end

      S_EXEC: begin
        load         = 1'b1;
        state_nxt    = S_IDLE;
        out_slot_nxt = '0;
        out_stat_nxt = STAT_DONE;
        out_gen_nxt  = '0;
        case (cmd_r)
          CMD_ALLOC: begin
            if (armed_r && qcnt_r != '0) begin
              // Pop the oldest freed slot; its link was read at accept.
              slot_wr_en   = 1'b1;
              slot_wr_addr = head_r;
              slot_wr_data = {1'b1, rd_gen};
              head_nxt     = link_rd_data;
              qcnt_nxt     = qcnt_r - CNT_W'(1);
              live_nxt     = live_r + CNT_W'(1);
              out_slot_nxt = SLOT_FW'(head_r);
              out_gen_nxt  = rd_gen;
            end else if (mark_r < CNT_W'(POOL_SLOTS)) begin
              // A fresh slot has never been written: generation zero.
              slot_wr_en   = 1'b1;
              slot_wr_addr = mark_r[SLOT_W-1:0];
              slot_wr_data = {1'b1, {GEN_W{1'b0}}};
              mark_nxt     = mark_r + CNT_W'(1);
              live_nxt     = live_r + CNT_W'(1);
              out_slot_nxt = SLOT_FW'(mark_r);
            end else begin
              out_stat_nxt = STAT_REFUSED;
            end
          end
          CMD_FREE: begin
            if (!tgt_ok_r || !rd_alive) begin
              out_stat_nxt = STAT_IGNORED;
            end else begin
              slot_wr_en   = 1'b1;
              slot_wr_addr = tgt_r;
              slot_wr_data = {1'b0,
                              (gen_inc >= GEN_W'(GEN_LIMIT)) ? {GEN_W{1'b0}} : gen_inc};
              live_nxt     = live_r - CNT_W'(1);
              if (armed_r) begin
                if (qcnt_r != '0) begin
                  link_wr_en   = 1'b1;
                  link_wr_addr = tail_r;
                  link_wr_data = tgt_r;
                end else begin
                  head_nxt = tgt_r;
                end
                tail_nxt = tgt_r;
                qcnt_nxt = qcnt_r + CNT_W'(1);
              end
            end
          end
          CMD_MODE: begin
            out_stat_nxt = STAT_DONE;
          end
          default: begin
            out_stat_nxt = STAT_IGNORED;
          end
        endcase
      end

      S_SCAN: begin
        // Queue the slot whose entry was read in the previous cycle if dead.
        if (scan_vld_r && !rd_alive) begin
          if (qcnt_r != '0) begin
            link_wr_en   = 1'b1;
            link_wr_addr = tail_r;
            link_wr_data = scan_slot_r;
          end else begin
            head_nxt = scan_slot_r;
          end
          tail_nxt = scan_slot_r;
          qcnt_nxt = qcnt_r + CNT_W'(1);
        end
        if (scan_idx_r < mark_r) begin
          slot_rd_en    = 1'b1;
          slot_rd_addr  = scan_idx_r[SLOT_W-1:0];
          scan_slot_nxt = scan_idx_r[SLOT_W-1:0];
          scan_idx_nxt  = scan_idx_r + CNT_W'(1);
          scan_vld_nxt  = 1'b1;
        end else begin
          scan_vld_nxt = 1'b0;
          if (!scan_vld_r) begin
            load         = 1'b1;
            state_nxt    = S_IDLE;
            out_slot_nxt = '0;
            out_stat_nxt = STAT_DONE;
            out_gen_nxt  = '0;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_live_nxt  = load ? CNT_FW'(live_nxt) : out_live_r;
    out_free_nxt  = load ? CNT_FW'(qcnt_nxt) : out_free_r;
    out_valid_nxt = load ? 1'b1 : (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      armed_r     <= 1'b0;
      mark_r      <= '0;
      live_r      <= '0;
      qcnt_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      scan_idx_r  <= '0;
      scan_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      armed_r     <= armed_nxt;
      mark_r      <= mark_nxt;
      live_r      <= live_nxt;
      qcnt_r      <= qcnt_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      scan_idx_r  <= scan_idx_nxt;
      scan_vld_r  <= scan_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_slot_r <= scan_slot_nxt;
    cmd_r       <= cmd_nxt;
    tgt_r       <= tgt_nxt;
    tgt_ok_r    <= tgt_ok_nxt;
    out_slot_r  <= out_slot_nxt;
    out_stat_r  <= out_stat_nxt;
    out_gen_r   <= out_gen_nxt;
    out_live_r  <= out_live_nxt;
    out_free_r  <= out_free_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_free_r, out_live_r, out_gen_r, out_slot_r};
  assign out_tuser  = out_stat_r;

`ifndef SYNTHESIS
  // Live slots and queued slots are disjoint subsets of the slots below the mark.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((CNT_W + 1)'(live_r) + (CNT_W + 1)'(qcnt_r)) <= (CNT_W + 1)'(mark_r))
    else $error("live plus queued slots exceed the high-water mark");

  // The high-water mark never moves backward.
  a_mark_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (mark_r >= $past(mark_r)))
    else $error("high-water mark decreased");

  // The result register is always empty while a command executes and its result is about to be loaded.
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> !out_valid_r)
    else $error("result register overwritten");

  // Nothing sits in the queue while recycling is disarmed.
  a_queue_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> (qcnt_r == '0))
    else $error("recycle queue not empty while disarmed");
`endif

endmodule

// ----- hw/rtl/sar_ram.sv -----
`timescale 1ns / 1ps

// Simple dual-port memory: one write port, one read port, registered read data.
module sar_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- verif/slot_allocator_fifo_recycle_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the slot allocator with generation counters and a
// recycle queue. Commands go in as beats on the input stream. A scoreboard
// object keeps its own copy of the slot pool and predicts the one reply that
// every command produces. Replies are checked in order as they leave the block.
module slot_allocator_fifo_recycle_tb;
  import sar_pkg::*;

  // The command field has one code with no meaning; the block must ignore it.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Longest quiet stretch we tolerate. Arming walks up to POOL_SLOTS_DEF
  // slots, and the long receiver hold-off adds to the quiet stretch. This
  // limit leaves plenty of margin on top of both.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int MAX_REPORTS    = 10;
  localparam int SEG_ITEMS      = 90;
  localparam int HOLDOFF_CYCLES = 300;

  typedef struct packed {
    logic [SLOT_FW-1:0] slot;
    logic [STAT_W-1:0]  status;
    logic [GEN_W-1:0]   gen;
    logic [CNT_FW-1:0]  alive;
    logic [CNT_FW-1:0]  queued;
  } reply_t;

  // Shadow copy of the slot pool. It is updated once per accepted command.
  class slot_tracker;
    bit                alive_map [POOL_SLOTS_DEF];
    bit [GEN_W-1:0]    gen_of    [POOL_SLOTS_DEF];
    bit [SLOT_FW-1:0]  link_of   [POOL_SLOTS_DEF];
    int unsigned       q_head, q_tail, q_count, mark, live;
    bit                armed;
    reply_t            pending_replies [$];
    int unsigned       n_cmds, n_checked, n_refused, n_reused, n_wraps, n_rebuilds;
    int unsigned       mismatches;

    function void enqueue_slot(int unsigned s);
      link_of[s] = '0;
      if (q_count == 0) q_head = s;
      else link_of[q_tail] = s[SLOT_FW-1:0];
      q_tail = s;
      q_count++;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [SLOT_FW-1:0] target, logic on);
      reply_t      r;
      int unsigned s;
      int unsigned bumped;
      bit          got;
      r = '0;
      r.status = STAT_DONE;
      got = 1'b0;
      s = 0;
      n_cmds++;
      case (cmd)
        CMD_ALLOC: begin
          if (armed && q_count != 0) begin
            s = q_head;
            q_head = 32'(link_of[s]);
            q_count--;
            if (q_count == 0) begin
              q_head = 0;
              q_tail = 0;
            end
            n_reused++;
            got = 1'b1;
          end else if (mark < POOL_SLOTS_DEF) begin
            s = mark;
            mark++;
            got = 1'b1;
          end else begin
            r.status = STAT_REFUSED;
            n_refused++;
          end
          if (got) begin
            alive_map[s] = 1'b1;
            live++;
            r.slot = s[SLOT_FW-1:0];
            r.gen  = gen_of[s];
          end
        end
        CMD_FREE: begin
          if (32'(target) >= mark || !alive_map[target]) begin
            r.status = STAT_IGNORED;
          end else begin
            bumped = gen_of[target] + 1;
            if (bumped >= GEN_LIMIT_DEF) begin
              bumped = 0;
              n_wraps++;
            end
            gen_of[target] = bumped[GEN_W-1:0];
            alive_map[target] = 1'b0;
            live--;
            if (armed) enqueue_slot(32'(target));
          end
        end
        CMD_MODE: begin
          if (on != armed) begin
            armed = on;
            q_head = 0;
            q_tail = 0;
            q_count = 0;
            if (on) begin
              n_rebuilds++;
              for (int unsigned i = 0; i < mark; i++)
                if (!alive_map[i]) enqueue_slot(i);
            end
          end
        end
        default: r.status = STAT_IGNORED;
      endcase
      r.alive  = live[CNT_FW-1:0];
      r.queued = q_count[CNT_FW-1:0];
      pending_replies.insert(pending_replies.size(), r);
    endfunction

    function void check_reply(logic [OUT_DATA_W-1:0] d, logic [STAT_W-1:0] u);
      reply_t seen;
      reply_t want;
      seen.slot   = d[SLOT_FW-1:0];
      seen.gen    = d[SLOT_FW +: GEN_W];
      seen.alive  = d[SLOT_FW+GEN_W +: CNT_FW];
      seen.queued = d[SLOT_FW+GEN_W+CNT_FW +: CNT_FW];
      seen.status = u;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result beat with nothing outstanding: slot %0d status %0d",
                   $realtime, seen.slot, seen.status);
        return;
      end
      want = pending_replies.pop_front();
      n_checked++;
      if (seen !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"[%0t] reply %0d mismatch: slot %0d/%0d status %0d/%0d gen %0d/%0d ",
                    "alive %0d/%0d queued %0d/%0d (expected/actual)"},
                   $realtime, n_checked, want.slot, seen.slot, want.status, seen.status,
                   want.gen, seen.gen, want.alive, seen.alive, want.queued, seen.queued);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [CMD_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]     out_tuser;

  slot_tracker tracker = new();

  // Idle rates of both sides, in percent of cycles. The main sequence sets
  // them per phase.
  int unsigned idle_in_pct   = 0;
  int unsigned stall_out_pct = 0;
  // A nonzero value asks the receiver to hold off for that many cycles.
  int unsigned holdoff_req   = 0;
  int unsigned quiet_cycles  = 0;

  slot_allocator_fifo_recycle u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one command, with random idle cycles in front of it, and hold it
  // until the block takes the beat. The valid line stays high when the next
  // command follows at once. It is written at most once per edge.
  task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [SLOT_FW-1:0] target,
                               input logic on);
    while ($urandom_range(99) < idle_in_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_DATA_W-SLOT_FW-1){1'b0}}, on, target};
    do @(posedge clk); while (in_tready !== 1'b1);
    tracker.note_command(cmd, target, on);
  endtask

  // Pick a slot that is live right now, so that most frees actually retire
  // something. With nothing live, any slot number will do.
  function automatic logic [SLOT_FW-1:0] live_target();
    int unsigned start;
    int unsigned s;
    if (tracker.live == 0) return SLOT_FW'($urandom_range(POOL_SLOTS_DEF-1));
    start = $urandom_range(tracker.mark-1);
    for (int unsigned k = 0; k < tracker.mark; k++) begin
      s = (start + k) % tracker.mark;
      if (tracker.alive_map[s]) return s[SLOT_FW-1:0];
    end
    return start[SLOT_FW-1:0];
  endfunction

  // Mostly meaningful traffic: allocates and frees of live slots. A share is
  // noise: stray frees of random slots, the unused code and mode changes.
  // The mode changes mostly flip the mode, so the queue gets rebuilt often.
  task automatic random_command(input int unsigned alloc_pct);
    int unsigned   r;
    logic [SLOT_FW-1:0] t;
    logic          on;
    r  = $urandom_range(99);
    t  = SLOT_FW'($urandom_range(POOL_SLOTS_DEF-1));
    on = 1'($urandom_range(1));
    if (r < 2) begin
      issue_command(CMD_UNUSED, t, on);
    end else if (r < 7) begin
      if ($urandom_range(3) != 0) on = ~tracker.armed;
      issue_command(CMD_MODE, t, on);
    end else if (r < 15) begin
      issue_command(CMD_FREE, t, on);
    end else if (r < 15 + alloc_pct * 85 / 100) begin
      issue_command(CMD_ALLOC, t, on);
    end else begin
      issue_command(CMD_FREE, live_target(), on);
    end
  endtask

  // Receiver: check every reply beat taken at this edge, then decide whether
  // to stall the next one. A hold-off request is counted down here, so the
  // sender keeps offering commands while the block backs up.
  initial begin
    int unsigned holdoff_left;
    holdoff_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready === 1'b1)
        tracker.check_reply(out_tdata, out_tuser);
      if (holdoff_left == 0 && holdoff_req != 0) begin
        holdoff_left = holdoff_req;
        holdoff_req = 0;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_out_pct);
      end
    end
  end

  // Watchdog: a beat on either side restarts the count of quiet cycles.
  initial begin
    forever begin
      @(posedge clk);
      if ((in_tvalid === 1'b1 && in_tready === 1'b1) ||
          (out_tvalid === 1'b1 && out_tready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no beat for %0d cycles, %0d replies outstanding",
                 $realtime, quiet_cycles, tracker.pending_replies.size());
        $display("FAIL slot_allocator_fifo_recycle");
        $finish;
      end
    end
  end

  initial begin
    int unsigned        seg;
    int unsigned        stall_mix [4];
    int unsigned        idle_mix  [4];
    int unsigned        alloc_mix [6];

    // The four idle profiles: none, sender only, receiver only, and both.
    idle_mix  = '{0, 67, 0, 22};
    stall_mix = '{0, 0, 67, 22};
    alloc_mix = '{55, 45, 60, 40, 50, 45};

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= CMD_ALLOC;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening with no idling. Arm on an empty pool, so the queue
    // stays empty. Arm again, which is a mode that is already set. Then
    // allocate while armed with nothing queued, which must take fresh slots.
    issue_command(CMD_MODE, 10'd0, 1'b1);
    issue_command(CMD_MODE, 10'd1023, 1'b1);
    issue_command(CMD_ALLOC, 10'd1023, 1'b0);
    issue_command(CMD_ALLOC, 10'd0, 1'b1);
    issue_command(CMD_ALLOC, 10'd0, 1'b0);
    // Retire slot 1 into the queue, then try it again while it is dead.
    issue_command(CMD_FREE, 10'd1, 1'b0);
    issue_command(CMD_FREE, 10'd1, 1'b1);
    // Frees at and far above the high-water mark are ignored.
    issue_command(CMD_FREE, 10'd1023, 1'b1);
    issue_command(CMD_FREE, 10'd3, 1'b0);
    // The queued slot comes back with its bumped generation.
    issue_command(CMD_ALLOC, 10'd0, 1'b0);
    issue_command(CMD_UNUSED, 10'd1023, 1'b1);
    issue_command(CMD_UNUSED, 10'd0, 1'b0);
    // Disarm. Frees no longer queue, and re-arming rebuilds the queue from
    // the dead slots below the mark in ascending order.
    issue_command(CMD_MODE, 10'd0, 1'b0);
    issue_command(CMD_FREE, 10'd2, 1'b1);
    issue_command(CMD_FREE, 10'd0, 1'b0);
    issue_command(CMD_MODE, 10'd1023, 1'b0);
    issue_command(CMD_MODE, 10'd0, 1'b1);
    issue_command(CMD_ALLOC, 10'd0, 1'b0);
    issue_command(CMD_ALLOC, 10'd0, 1'b0);
    issue_command(CMD_ALLOC, 10'd0, 1'b0);
    issue_command(CMD_MODE, 10'd0, 1'b0);
    issue_command(CMD_FREE, 10'd0, 1'b1);

    // Random traffic in segments that rotate through the idle profiles. The
    // third segment first fills the whole pool with recycling off. It runs
    // under a long receiver hold-off, so the input backs up. The fill ends with
    // three refused allocates, ahead of that segment's random commands.
    for (seg = 0; seg < 6; seg++) begin
      idle_in_pct   = idle_mix[seg % 4];
      stall_out_pct = stall_mix[seg % 4];
      if (seg == 2) begin
        holdoff_req = HOLDOFF_CYCLES;
        issue_command(CMD_MODE, SLOT_FW'($urandom_range(POOL_SLOTS_DEF-1)), 1'b0);
        while (tracker.mark < POOL_SLOTS_DEF)
          issue_command(CMD_ALLOC, SLOT_FW'($urandom_range(POOL_SLOTS_DEF-1)),
                        1'($urandom_range(1)));
        repeat (3)
          issue_command(CMD_ALLOC, SLOT_FW'($urandom_range(POOL_SLOTS_DEF-1)),
                        1'($urandom_range(1)));
      end
      repeat (SEG_ITEMS) random_command(alloc_mix[seg]);
    end
    in_tvalid <= 1'b0;

    // Drain, then watch a little longer for stray beats.
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("Covered %0d commands, %0d replies checked: %0d refusals, %0d recycled grants,",
             tracker.n_cmds, tracker.n_checked, tracker.n_refused, tracker.n_reused);
    $display("%0d queue rebuilds on arming, %0d generation wraps, %0d mismatching beats.",
             tracker.n_rebuilds, tracker.n_wraps, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("PASS slot_allocator_fifo_recycle");
    end else begin
      $display("FAIL slot_allocator_fifo_recycle");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/sar_pkg.sv
hw/rtl/sar_ram.sv
hw/rtl/slot_allocator_fifo_recycle.sv
verif/slot_allocator_fifo_recycle_tb.sv
